// ===== hdl/psa_pkg.sv =====
package psa_pkg;

  // Amount format
  localparam int POUND_BITS     = 32;
  localparam int DIV_FRAC_BITS  = 8;
  localparam int SH_W           = 5;
  localparam int PE_W           = 4;
  localparam int FAC_W          = 16;
  localparam int DIV_W          = 24;
  localparam int RES_POUNDS_W   = 32;

  localparam int PENCE_PER_SHILLING  = 12;
  localparam int SHILLINGS_PER_POUND = 20;
  localparam int PENCE_PER_POUND     = 240;

  // Quotient by twelve for values below 240: (x * 171) >> 11
  localparam int DIV12_MUL   = 171;
  localparam int DIV12_SHIFT = 11;
  localparam int DIV12_W     = 16;

  // Internal widths
  localparam int SMALL_W   = 9;                         // sub-pound pence, up to 387
  localparam int SUM_W     = SMALL_W + 1;               // sum of two sub-pound parts
  localparam int REM_W     = 8;                         // pence below one pound
  localparam int TOT_W     = POUND_BITS + REM_W;        // whole amount in pence
  localparam int MUL_W     = POUND_BITS + FAC_W;
  localparam int PRE_W     = MUL_W + 1;
  localparam int XA_W      = TOT_W + DIV_FRAC_BITS;
  localparam int XB_W      = SMALL_W + FAC_W;
  localparam int X_W       = (XA_W > XB_W) ? XA_W : XB_W;
  localparam int DSR_W     = DIV_W + REM_W;             // divisor times 240
  localparam int NSTG      = 1 + X_W + REM_W;

  // Transaction layout
  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [POUND_BITS-1:0] pounds_t;
  typedef logic [SMALL_W-1:0]    small_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    pounds_t             ap;
    pounds_t             bp;
    small_t              as;
    small_t              bs;
    logic [FAC_W-1:0]    f;
    logic [DIV_W-1:0]    dv;
    logic                dz;
  } front_t;

  typedef struct packed {
    op_t                 op;
    logic                dz;
    logic [PRE_W-1:0]    pre;
    logic [REM_W-1:0]    pre_small;
    logic [X_W-1:0]      xq;
    logic [DSR_W-1:0]    rem;
    logic [DSR_W-1:0]    dsr;
    logic [DIV_W-1:0]    dv;
    logic [DIV_W-1:0]    r2;
    logic [REM_W-1:0]    rlo;
    logic [REM_W-1:0]    q2;
  } lane_t;

  typedef struct packed {
    logic [RES_POUNDS_W-1:0] pounds;
    logic [SH_W-1:0]         sh;
    logic [PE_W-1:0]         pe;
    status_t                 st;
  } res_t;

endpackage

// ===== hdl/psa_front.sv =====
module psa_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [psa_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [psa_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                f_valid,
  input  logic                                f_ready,
  output psa_pkg::front_t                     f_data
);

  logic            front_v_r;
  logic            front_v_nxt;
  psa_pkg::front_t front_r;
  psa_pkg::front_t front_nxt;
  logic            accept;

  assign in_tready = !front_v_r || f_ready;
  assign accept    = in_tvalid && in_tready;
  assign f_valid   = front_v_r;
  assign f_data    = front_r;

  // Unpack and classify the incoming transaction
  always_comb begin
    front_nxt.op = psa_pkg::op_t'(in_tuser);
    front_nxt.ap = psa_pkg::pounds_t'(in_tdata[31:0]);
    front_nxt.as = psa_pkg::small_t'(in_tdata[36:32])
                   * psa_pkg::small_t'(psa_pkg::PENCE_PER_SHILLING)
                   + psa_pkg::small_t'(in_tdata[40:37]);
    front_nxt.bp = psa_pkg::pounds_t'(in_tdata[72:41]);
    front_nxt.bs = psa_pkg::small_t'(in_tdata[77:73])
                   * psa_pkg::small_t'(psa_pkg::PENCE_PER_SHILLING)
                   + psa_pkg::small_t'(in_tdata[81:78]);
    front_nxt.f  = in_tdata[97:82];
    front_nxt.dv = in_tdata[121:98];
    front_nxt.dz = (in_tdata[121:98] == '0);
  end

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (f_ready) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  // Hold the payload until the queue takes it
  always_ff @(posedge clk) begin
    if (accept) begin
      front_r <= front_nxt;
    end
  end

endmodule

// ===== hdl/psa_queue.sv =====
module psa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  psa_pkg::front_t push_data,
  output logic            pop_valid,
  input  logic            pop,
  output psa_pkg::front_t pop_data
);

  psa_pkg::front_t                 mem_r [psa_pkg::Q_DEPTH];
  logic [psa_pkg::Q_PTR_W-1:0]     wr_ptr_r;
  logic [psa_pkg::Q_PTR_W-1:0]     rd_ptr_r;
  logic [psa_pkg::Q_CNT_W-1:0]     count_r;
  logic [psa_pkg::Q_CNT_W-1:0]     count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count_r != psa_pkg::Q_CNT_W'(psa_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + psa_pkg::Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - psa_pkg::Q_CNT_W'(1);
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/psa_back.sv =====
module psa_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  psa_pkg::front_t q_data,
  output logic            out_valid,
  input  logic            out_ready,
  output psa_pkg::res_t   out_res
);

  localparam int NSTG = psa_pkg::NSTG;
  localparam int XW   = psa_pkg::X_W;

  psa_pkg::lane_t lane_r   [NSTG];
  psa_pkg::lane_t lane_nxt [NSTG];
  logic           valid_r  [NSTG];
  logic           out_valid_r;
  psa_pkg::res_t  out_res_r;
  logic           adv;

  // Operand set-up: one multiplier shared by multiply and divide
  function automatic psa_pkg::lane_t setup(input psa_pkg::front_t fr);
    psa_pkg::lane_t                    l;
    logic [psa_pkg::FAC_W-1:0]         mf;
    logic [psa_pkg::MUL_W-1:0]         m;
    logic [psa_pkg::TOT_W-1:0]         t;
    logic [psa_pkg::SUM_W-1:0]         s;
    logic signed [psa_pkg::SUM_W:0]    d;
    logic signed [2:0]                 qs;
    logic [1:0]                        qa;
    l           = '0;
    l.op        = fr.op;
    l.dz        = fr.dz;
    l.dv        = fr.dv;
    l.dsr       = psa_pkg::DSR_W'(psa_pkg::PENCE_PER_POUND);
    mf          = (fr.op == psa_pkg::OP_MUL) ? fr.f
                                             : psa_pkg::FAC_W'(psa_pkg::PENCE_PER_POUND);
    m           = psa_pkg::MUL_W'(fr.ap) * psa_pkg::MUL_W'(mf);
    t           = psa_pkg::TOT_W'(m) + psa_pkg::TOT_W'(fr.as);
    s           = psa_pkg::SUM_W'(fr.as) + psa_pkg::SUM_W'(fr.bs);
    d           = $signed({2'b00, fr.as}) - $signed({2'b00, fr.bs});
    qa          = 2'd0;
    qs          = 3'sd0;
    unique case (fr.op)
      psa_pkg::OP_ADD: begin
        priority if (s >= psa_pkg::SUM_W'(3 * psa_pkg::PENCE_PER_POUND)) begin
          qa = 2'd3;
        end else if (s >= psa_pkg::SUM_W'(2 * psa_pkg::PENCE_PER_POUND)) begin
          qa = 2'd2;
        end else if (s >= psa_pkg::SUM_W'(psa_pkg::PENCE_PER_POUND)) begin
          qa = 2'd1;
        end else begin
          qa = 2'd0;
        end
        l.pre_small = psa_pkg::REM_W'(s - psa_pkg::SUM_W'(qa) *
                                          psa_pkg::SUM_W'(psa_pkg::PENCE_PER_POUND));
        l.pre       = psa_pkg::PRE_W'(fr.ap) + psa_pkg::PRE_W'(fr.bp) + psa_pkg::PRE_W'(qa);
      end
      psa_pkg::OP_SUB: begin
        priority if (d >= 240) begin
          qs          = 3'sd1;
          l.pre_small = psa_pkg::REM_W'(d - 240);
        end else if (d >= 0) begin
          qs          = 3'sd0;
          l.pre_small = psa_pkg::REM_W'(d);
        end else if (d >= -240) begin
          qs          = -3'sd1;
          l.pre_small = psa_pkg::REM_W'(d + 240);
        end else begin
          qs          = -3'sd2;
          l.pre_small = psa_pkg::REM_W'(d + 480);
        end
        l.pre = psa_pkg::PRE_W'(fr.ap) - psa_pkg::PRE_W'(fr.bp) + psa_pkg::PRE_W'(qs);
      end
      psa_pkg::OP_MUL: begin
        l.pre = psa_pkg::PRE_W'(m);
        l.xq  = XW'(fr.as) * XW'(fr.f);
      end
      psa_pkg::OP_DIV: begin
        l.xq  = XW'(t) << psa_pkg::DIV_FRAC_BITS;
        l.dsr = psa_pkg::DSR_W'(fr.dv) * psa_pkg::DSR_W'(psa_pkg::PENCE_PER_POUND);
      end
      default: l = '0;
    endcase
    return l;
  endfunction

  // One restoring step: dividend bit out of the top, quotient bit in at the bottom
  function automatic psa_pkg::lane_t div_step(input psa_pkg::lane_t li);
    psa_pkg::lane_t           l;
    logic [psa_pkg::DSR_W:0]  s;
    l    = li;
    s    = {li.rem, li.xq[XW-1]};
    l.xq = li.xq << 1;
    if (s >= {1'b0, li.dsr}) begin
      s       = s - {1'b0, li.dsr};
      l.xq[0] = 1'b1;
    end
    l.rem = s[psa_pkg::DSR_W-1:0];
    return l;
  endfunction

  // Remainder over the plain divisor gives the pence below one pound
  function automatic psa_pkg::lane_t frac_step(input psa_pkg::lane_t li, input logic first);
    psa_pkg::lane_t            l;
    logic [psa_pkg::DIV_W-1:0] r;
    logic [psa_pkg::REM_W-1:0] lo;
    logic [psa_pkg::DIV_W:0]   s;
    l = li;
    if (first) begin
      r  = li.rem[psa_pkg::DSR_W-1:psa_pkg::REM_W];
      lo = li.rem[psa_pkg::REM_W-1:0];
    end else begin
      r  = li.r2;
      lo = li.rlo;
    end
    s     = {r, lo[psa_pkg::REM_W-1]};
    l.rlo = lo << 1;
    l.q2  = li.q2 << 1;
    if (s >= {1'b0, li.dv}) begin
      s       = s - {1'b0, li.dv};
      l.q2[0] = 1'b1;
    end
    l.r2 = s[psa_pkg::DIV_W-1:0];
    return l;
  endfunction

  // Pick the result, flag it and split the pence into shillings and pence
  function automatic psa_pkg::res_t finish(input psa_pkg::lane_t l);
    psa_pkg::res_t               r;
    logic [psa_pkg::PRE_W-1:0]   plo;
    logic [psa_pkg::REM_W-1:0]   sub_pence;
    logic [psa_pkg::DIV12_W-1:0] prod;
    logic [psa_pkg::SH_W-1:0]    sh;
    logic                        zero;
    plo       = '0;
    sub_pence = '0;
    zero      = 1'b0;
    r.st      = psa_pkg::ST_OK;
    unique case (l.op)
      psa_pkg::OP_ADD: begin
        plo       = l.pre;
        sub_pence = l.pre_small;
        r.st      = (|plo[psa_pkg::PRE_W-1:psa_pkg::POUND_BITS]) ? psa_pkg::ST_OVF
                                                                 : psa_pkg::ST_OK;
      end
      psa_pkg::OP_SUB: begin
        if (l.pre[psa_pkg::PRE_W-1]) begin
          zero = 1'b1;
          r.st = psa_pkg::ST_NEG;
        end else begin
          plo       = l.pre;
          sub_pence = l.pre_small;
        end
      end
      psa_pkg::OP_MUL: begin
        plo       = l.pre + psa_pkg::PRE_W'(l.xq);
        sub_pence = l.rem[psa_pkg::REM_W-1:0];
        r.st      = (|plo[psa_pkg::PRE_W-1:psa_pkg::POUND_BITS]) ? psa_pkg::ST_OVF
                                                                 : psa_pkg::ST_OK;
      end
      psa_pkg::OP_DIV: begin
        if (l.dz) begin
          zero = 1'b1;
          r.st = psa_pkg::ST_DIVZ;
        end else begin
          plo       = psa_pkg::PRE_W'(l.xq);
          sub_pence = l.q2;
          r.st      = (|l.xq[XW-1:psa_pkg::POUND_BITS]) ? psa_pkg::ST_OVF : psa_pkg::ST_OK;
        end
      end
      default: zero = 1'b1;
    endcase
    if (zero) begin
      plo       = '0;
      sub_pence = '0;
    end
    prod     = psa_pkg::DIV12_W'(sub_pence) * psa_pkg::DIV12_W'(psa_pkg::DIV12_MUL);
    sh       = psa_pkg::SH_W'(prod >> psa_pkg::DIV12_SHIFT);
    r.sh     = sh;
    r.pe     = psa_pkg::PE_W'(sub_pence - psa_pkg::REM_W'(sh) *
                                          psa_pkg::REM_W'(psa_pkg::PENCE_PER_SHILLING));
    r.pounds = psa_pkg::RES_POUNDS_W'(plo[psa_pkg::POUND_BITS-1:0]);
    return r;
  endfunction

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Stage logic: set-up, long division, fraction division
  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    if (i == 0) begin : g_setup
      always_comb lane_nxt[i] = setup(q_data);
    end else if (i <= XW) begin : g_div
      always_comb lane_nxt[i] = div_step(lane_r[i-1]);
    end else begin : g_frac
      always_comb lane_nxt[i] = frac_step(lane_r[i-1], (i == XW + 1));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= (i == 0) ? q_valid : valid_r[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lane_r[i] <= lane_nxt[i];
      end
    end
  end

  // Output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= finish(lane_r[NSTG-1]);
    end
  end

endmodule

// ===== hdl/pounds_shillings_pence_alu_core.sv =====
// Arithmetic on pounds, shillings and pence (12d to the shilling, 20s to the pound).
// Input channel in_*: one transaction per operation. in_tuser carries the opcode
// (add, subtract, multiply by factor, divide by a 16.8 divisor); in_tdata carries
// both amounts, the factor and the divisor.
// Output channel out_*: exactly one transaction per input, in order. out_tdata holds
// the normalised amount, out_tuser the status (ok, negative zeroed, divide by zero
// zeroed, pounds overflow with the value wrapped).
// From input acceptance to out_tvalid a transaction passes the front register, which takes
// it at acceptance, then one queue slot, a set-up stage, 48 restoring divider stages
// (one quotient bit each), 8 stages dividing the remainder for the pence part, and
// the output register.
// Every operation passes through the same divider pipeline, so one transaction is
// accepted per cycle for as long as the receiver keeps out_tready high.
// A stall on out_tready freezes the back pipeline; the two-entry queue and the front
// register keep taking input until they fill, then in_tready drops.
// Reset (rst_n low, synchronous) empties the front register, queue and pipeline;
// no state survives between operations.
module pounds_shillings_pence_alu_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_pounds, a_shillings, a_pence, b_pounds, b_shillings, b_pence, factor, divisor_q8
  input  logic [psa_pkg::IN_TDATA_W-1:0]       in_tdata,
  // opcode
  input  logic [psa_pkg::IN_TUSER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // res_pounds, res_shillings, res_pence
  output logic [psa_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status
  output logic [psa_pkg::OUT_TUSER_W-1:0]      out_tuser
);

  logic            f_valid;
  logic            f_ready;
  psa_pkg::front_t f_data;
  logic            q_valid;
  logic            q_pop;
  psa_pkg::front_t q_data;
  psa_pkg::res_t   res;

  psa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_data    (f_data)
  );

  psa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  psa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result transaction
  assign out_tdata = psa_pkg::OUT_TDATA_W'({res.pe, res.sh, res.pounds});
  assign out_tuser = res.st;

  // Zeroed results carry no amount
  a_zeroed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == psa_pkg::ST_NEG || out_tuser == psa_pkg::ST_DIVZ)
    |-> out_tdata == '0)
    else $error("zeroed result carries a non-zero amount");

  // Results leave normalised
  a_normalised: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[36:32] < psa_pkg::SH_W'(psa_pkg::SHILLINGS_PER_POUND) &&
      out_tdata[40:37] < psa_pkg::PE_W'(psa_pkg::PENCE_PER_SHILLING))
    else $error("result shillings or pence out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented straight after reset");

endmodule

// ===== tb/tb_pounds_shillings_pence_alu_core.sv =====
`timescale 1ns / 100ps

module tb_pounds_shillings_pence_alu_core;

  localparam int CLK_HALF  = 6;
  localparam int MAX_CYC   = 400000;
  localparam int LATENCY   = 59;

  typedef struct {
    psa_pkg::op_t op;
    logic [31:0]  ap;
    logic [4:0]   ash;
    logic [3:0]   ape;
    logic [31:0]  bp;
    logic [4:0]   bsh;
    logic [3:0]   bpe;
    logic [15:0]  fac;
    logic [23:0]  dvq;
  } money_op_t;

  typedef struct {
    logic [31:0]      pounds;
    logic [4:0]       sh;
    logic [3:0]       pe;
    psa_pkg::status_t st;
  } money_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [psa_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [psa_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [psa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [psa_pkg::OUT_TUSER_W-1:0] out_tuser;

  money_res_t pending_sums[$];
  int         fail_count;
  int         cycle_count;

  pounds_shillings_pence_alu_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Work out the normalised amount and status for one operation
  function automatic money_res_t reckon(money_op_t m);
    money_res_t r;
    logic [127:0] at;
    logic [127:0] bt;
    logic [127:0] t;
    logic [127:0] q;
    logic [127:0] qp;
    at = 128'(m.ap) * psa_pkg::PENCE_PER_POUND
         + 128'(m.ash) * psa_pkg::PENCE_PER_SHILLING + 128'(m.ape);
    bt = 128'(m.bp) * psa_pkg::PENCE_PER_POUND
         + 128'(m.bsh) * psa_pkg::PENCE_PER_SHILLING + 128'(m.bpe);
    r.st = psa_pkg::ST_OK;
    t = '0;
    case (m.op)
      psa_pkg::OP_ADD: t = at + bt;
      psa_pkg::OP_SUB: begin
        if (at < bt) r.st = psa_pkg::ST_NEG;
        else t = at - bt;
      end
      psa_pkg::OP_MUL: t = at * 128'(m.fac);
      default: begin
        if (m.dvq == 0) r.st = psa_pkg::ST_DIVZ;
        else t = (at << psa_pkg::DIV_FRAC_BITS) / 128'(m.dvq);
      end
    endcase
    qp = t / psa_pkg::PENCE_PER_POUND;
    q = t % psa_pkg::PENCE_PER_POUND;
    // A difference wraps its pounds silently; other operations flag the overflow
    if (r.st == psa_pkg::ST_OK && m.op != psa_pkg::OP_SUB &&
        qp[127:psa_pkg::POUND_BITS] != 0) r.st = psa_pkg::ST_OVF;
    r.pounds = qp[31:0];
    r.sh = 5'(q / psa_pkg::PENCE_PER_SHILLING);
    r.pe = 4'(q % psa_pkg::PENCE_PER_SHILLING);
    return r;
  endfunction

  // Send one operation, with a random gap between bursts
  task automatic send_op(money_op_t m);
    in_tvalid <= 1'b1;
    in_tuser  <= m.op;
    in_tdata  <= {39'd0, m.dvq, m.fac, m.bpe, m.bsh, m.bp, m.ape, m.ash, m.ap};
    pending_sums.push_back(reckon(m));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic money_op_t rand_op();
    money_op_t m;
    m.op  = psa_pkg::op_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: m.ap = $urandom_range(0, 50);
      1: m.ap = 32'hFFFF_FFFF - $urandom_range(0, 50);
      default: m.ap = $urandom;
    endcase
    m.bp  = ($urandom_range(0, 2) == 0) ? m.ap : 32'($urandom);
    // Mostly normalised, sometimes the full field
    m.ash = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 19));
    m.ape = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
    m.bsh = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 19));
    m.bpe = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
    m.fac = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    case ($urandom_range(0, 4))
      0: m.dvq = 24'($urandom_range(0, 2));
      1: m.dvq = 24'hFF_FFFF;
      default: m.dvq = 24'($urandom);
    endcase
    return m;
  endfunction

  function automatic money_op_t mk(psa_pkg::op_t op, logic [31:0] ap, logic [4:0] ash,
                                   logic [3:0] ape, logic [31:0] bp, logic [4:0] bsh,
                                   logic [3:0] bpe, logic [15:0] fac, logic [23:0] dvq);
    money_op_t m;
    m.op = op; m.ap = ap; m.ash = ash; m.ape = ape;
    m.bp = bp; m.bsh = bsh; m.bpe = bpe; m.fac = fac; m.dvq = dvq;
    return m;
  endfunction

  // Directed: extremes, carries, negative, divide by zero, overflow
  task automatic test_directed();
    send_op(mk(psa_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk(psa_pkg::OP_ADD, 1, 19, 11, 2, 0, 1, 16'hFFFF, 24'hFFFFFF));
    send_op(mk(psa_pkg::OP_ADD, 32'hFFFFFFFF, 19, 11, 0, 0, 1, 0, 0));
    send_op(mk(psa_pkg::OP_ADD, 32'hFFFFFFFF, 31, 15, 32'hFFFFFFFF, 31, 15, 0, 0));
    send_op(mk(psa_pkg::OP_SUB, 5, 0, 0, 4, 19, 11, 0, 0));
    send_op(mk(psa_pkg::OP_SUB, 4, 19, 11, 5, 0, 0, 0, 0));
    send_op(mk(psa_pkg::OP_SUB, 7, 3, 3, 7, 3, 3, 0, 0));
    send_op(mk(psa_pkg::OP_SUB, 32'hFFFFFFFF, 31, 15, 0, 0, 0, 0, 0));
    send_op(mk(psa_pkg::OP_MUL, 3, 5, 6, 0, 0, 0, 0, 0));
    send_op(mk(psa_pkg::OP_MUL, 0, 19, 11, 0, 0, 0, 16'hFFFF, 0));
    send_op(mk(psa_pkg::OP_MUL, 32'hFFFFFFFF, 31, 15, 0, 0, 0, 16'hFFFF, 0));
    send_op(mk(psa_pkg::OP_MUL, 1, 0, 0, 0, 0, 0, 1, 0));
    send_op(mk(psa_pkg::OP_DIV, 10, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk(psa_pkg::OP_DIV, 10, 5, 5, 0, 0, 0, 0, 24'h000100));
    send_op(mk(psa_pkg::OP_DIV, 32'hFFFFFFFF, 31, 15, 0, 0, 0, 0, 24'h000001));
    send_op(mk(psa_pkg::OP_DIV, 32'hFFFFFFFF, 19, 11, 0, 0, 0, 0, 24'hFFFFFF));
    send_op(mk(psa_pkg::OP_DIV, 1, 0, 0, 0, 0, 0, 0, 24'h000180));
    send_op(mk(psa_pkg::OP_DIV, 0, 0, 1, 0, 0, 0, 0, 24'h000080));
  endtask

  task automatic test_random();
    repeat (550) send_op(rand_op());
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ((cycle_count / 300) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    money_res_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result %h/%h", $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        e = pending_sums.pop_front();
        if (out_tdata[31:0] !== e.pounds || out_tdata[36:32] !== e.sh ||
            out_tdata[40:37] !== e.pe || out_tdata[47:41] !== 7'd0 ||
            out_tuser !== e.st) begin
          $display("%0t: mismatch expected %0d/%0d/%0d st %0d actual %0d/%0d/%0d st %0d",
                   $time, e.pounds, e.sh, e.pe, e.st, out_tdata[31:0],
                   out_tdata[36:32], out_tdata[40:37], out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Hold the run to a generous cycle limit
  always @(posedge clk) begin
    if (cycle_count > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
